// ===== hdl/ctc_pkg.sv =====
// ----------------------------------------------------------------------------
// ctc_pkg
// Shared types, token codes, lexer modes and the lexer step function.
// ----------------------------------------------------------------------------
`default_nettype none

package ctc_pkg;

    localparam int unsigned NUM_KW = 44;
    localparam int unsigned MAX_TOK = 3;
    localparam logic [8:0] FLUSH_CH = 9'h100;

    typedef enum logic [5:0] {
        TK_LSQ, TK_RSQ, TK_LPR, TK_RPR, TK_LBR, TK_RBR, TK_DOTS3, TK_ERR,
        TK_DOT, TK_ARROW, TK_MM, TK_SUBEQ, TK_SUB, TK_PP, TK_ADDEQ, TK_ADD,
        TK_ANDAND, TK_ANDEQ, TK_AMP, TK_MULEQ, TK_MUL, TK_TIL, TK_NE, TK_BANG,
        TK_DIVEQ, TK_SL, TK_PCEQ, TK_PC, TK_SHLEQ, TK_SHL, TK_LE, TK_LESS,
        TK_SHREQ, TK_SHR, TK_GE, TK_MORE, TK_EQEQ, TK_ASSIGN, TK_XOREQ,
        TK_CARET, TK_OROR, TK_OREQ, TK_BAR, TK_QUES, TK_COL, TK_SEMI,
        TK_COMMA, TK_HH, TK_H, TK_KW, TK_ID, TK_HEXF, TK_HEXI, TK_FLT,
        TK_OCT, TK_STR, TK_DEC, TK_BAD
    } t_tok;

    typedef enum logic [4:0] {
        M_IDLE, M_LINE, M_BLK, M_BLKSTAR, M_STR, M_STRESC, M_IDENT, M_DOT1,
        M_DOT2, M_MINUS, M_PLUS, M_AMP, M_STAR, M_BANG, M_SLASH, M_PERC,
        M_LT, M_LT2, M_GT, M_GT2, M_EQ, M_CARET, M_BAR, M_HASH, M_ZERO,
        M_OCT, M_DECN, M_EXPS, M_EXP, M_HEX, M_HEXEXPS, M_HEXEXP
    } t_mode;

    typedef struct packed {
        t_mode        mode;
        logic         flt;
        logic [43:0]  hits;
        logic [3:0]   len;
        logic         halt;
    } t_lex_st;

    typedef struct packed {
        t_lex_st     st;
        logic        used;
        logic [1:0]  n;
        t_tok        tk0;
        t_tok        tk1;
    } t_lex_res;

    // up to three tokens caused by one input byte
    typedef struct packed {
        logic [1:0]       cnt;
        logic [2:0][5:0]  kinds;
    } t_bundle;

    function automatic logic eq(input logic [8:0] c, input logic [7:0] ch);
        return c == {1'b0, ch};
    endfunction

    function automatic logic is_digit(input logic [8:0] c);
        return c >= 9'h030 && c <= 9'h039;
    endfunction

    function automatic logic is_hex(input logic [8:0] c);
        return is_digit(c) || (c >= 9'h061 && c <= 9'h066)
            || (c >= 9'h041 && c <= 9'h046);
    endfunction

    function automatic logic is_alpha(input logic [8:0] c);
        return (c >= 9'h061 && c <= 9'h07a) || (c >= 9'h041 && c <= 9'h05a)
            || eq(c, "_");
    endfunction

    function automatic logic [7:0] kw_char(input int unsigned k, input logic [3:0] p);
        logic [119:0] s;
        int unsigned  l;
        int unsigned  b;
        s = '0;
        l = 0;
        unique case (k)
            0:  begin s = 120'("auto");     l = 4;  end
            1:  begin s = 120'("break");    l = 5;  end
            2:  begin s = 120'("case");     l = 4;  end
            3:  begin s = 120'("char");     l = 4;  end
            4:  begin s = 120'("const");    l = 5;  end
            5:  begin s = 120'("continue"); l = 8;  end
            6:  begin s = 120'("default");  l = 7;  end
            7:  begin s = 120'("do");       l = 2;  end
            8:  begin s = 120'("double");   l = 6;  end
            9:  begin s = 120'("else");     l = 4;  end
            10: begin s = 120'("enum");     l = 4;  end
            11: begin s = 120'("extern");   l = 6;  end
            12: begin s = 120'("float");    l = 5;  end
            13: begin s = 120'("for");      l = 3;  end
            14: begin s = 120'("goto");     l = 4;  end
            15: begin s = 120'("if");       l = 2;  end
            16: begin s = 120'("inline");   l = 6;  end
            17: begin s = 120'("int");      l = 3;  end
            18: begin s = 120'("long");     l = 4;  end
            19: begin s = 120'("register"); l = 8;  end
            20: begin s = 120'("restrict"); l = 8;  end
            21: begin s = 120'("return");   l = 6;  end
            22: begin s = 120'("short");    l = 5;  end
            23: begin s = 120'("signed");   l = 6;  end
            24: begin s = 120'("sizeof");   l = 6;  end
            25: begin s = 120'("static");   l = 6;  end
            26: begin s = 120'("struct");   l = 6;  end
            27: begin s = 120'("switch");   l = 6;  end
            28: begin s = 120'("typedef");  l = 7;  end
            29: begin s = 120'("union");    l = 5;  end
            30: begin s = 120'("unsigned"); l = 8;  end
            31: begin s = 120'("void");     l = 4;  end
            32: begin s = 120'("volatile"); l = 8;  end
            33: begin s = 120'("while");    l = 5;  end
            34: begin s = 120'("_Alignas"); l = 8;  end
            35: begin s = 120'("_Alignof"); l = 8;  end
            36: begin s = 120'("_Atomic");  l = 7;  end
            37: begin s = 120'("_Bool");    l = 5;  end
            38: begin s = 120'("_Complex"); l = 8;  end
            39: begin s = 120'("_Generic"); l = 8;  end
            40: begin s = 120'("_Imaginary"); l = 10; end
            41: begin s = 120'("_Noreturn"); l = 9; end
            42: begin s = 120'({"_Static", "_assert"}); l = 14; end
            default: begin s = 120'({"_Thread", "_local"}); l = 13; end
        endcase
        if (32'(p) < l) begin
            b = (l - 1 - 32'(p)) * 8;
            return s[b +: 8];
        end
        return 8'h00;
    endfunction

    function automatic int unsigned kw_len(input int unsigned k);
        int unsigned l;
        l = 0;
        for (int unsigned p = 0; p < 15; p++) begin
            if (kw_char(k, 4'(p)) != 8'h00) l = p + 1;
        end
        return l;
    endfunction

    function automatic t_lex_st kw_step(input t_lex_st s, input logic [8:0] c);
        t_lex_st r;
        r = s;
        if (s.len == 4'd15) begin
            r.hits = '0;
        end else begin
            for (int unsigned k = 0; k < NUM_KW; k++) begin
                if (!eq(c, kw_char(k, s.len))) r.hits[k] = 1'b0;
            end
            r.len = s.len + 4'd1;
        end
        return r;
    endfunction

    function automatic t_tok ident_kind(input t_lex_st s);
        t_tok t;
        t = TK_ID;
        if (s.len <= 4'd14) begin
            for (int unsigned k = 0; k < NUM_KW; k++) begin
                if (s.hits[k] && kw_len(k) == 32'(s.len)) t = TK_KW;
            end
        end
        return t;
    endfunction

    // one pass of the lexer over character c; used clear means lex c again
    function automatic t_lex_res lex_step(input t_lex_st s, input logic [8:0] c);
        t_lex_res r;
        logic     fl;
        logic     isexp;
        r.st = s;
        r.used = 1'b1;
        r.n = 2'd0;
        r.tk0 = TK_LSQ;
        r.tk1 = TK_LSQ;
        fl = (c == FLUSH_CH);
        isexp = eq(c, "+") || eq(c, "-") || is_digit(c);
        unique case (s.mode)
            M_IDLE: begin
                if (!fl) begin
                    r.n = 2'd1;
                    priority if (eq(c, "[")) r.tk0 = TK_LSQ;
                    else if (eq(c, "]")) r.tk0 = TK_RSQ;
                    else if (eq(c, "(")) r.tk0 = TK_LPR;
                    else if (eq(c, ")")) r.tk0 = TK_RPR;
                    else if (eq(c, "{")) r.tk0 = TK_LBR;
                    else if (eq(c, "}")) r.tk0 = TK_RBR;
                    else if (eq(c, "~")) r.tk0 = TK_TIL;
                    else if (eq(c, "?")) r.tk0 = TK_QUES;
                    else if (eq(c, ":")) r.tk0 = TK_COL;
                    else if (eq(c, ";")) r.tk0 = TK_SEMI;
                    else if (eq(c, ",")) r.tk0 = TK_COMMA;
                    else begin
                        r.n = 2'd0;
                        priority if (eq(c, ".")) r.st.mode = M_DOT1;
                        else if (eq(c, "-")) r.st.mode = M_MINUS;
                        else if (eq(c, "+")) r.st.mode = M_PLUS;
                        else if (eq(c, "&")) r.st.mode = M_AMP;
                        else if (eq(c, "*")) r.st.mode = M_STAR;
                        else if (eq(c, "!")) r.st.mode = M_BANG;
                        else if (eq(c, "/")) r.st.mode = M_SLASH;
                        else if (eq(c, "%")) r.st.mode = M_PERC;
                        else if (eq(c, "<")) r.st.mode = M_LT;
                        else if (eq(c, ">")) r.st.mode = M_GT;
                        else if (eq(c, "=")) r.st.mode = M_EQ;
                        else if (eq(c, "^")) r.st.mode = M_CARET;
                        else if (eq(c, "|")) r.st.mode = M_BAR;
                        else if (eq(c, "#")) r.st.mode = M_HASH;
                        else if (eq(c, "\"")) r.st.mode = M_STR;
                        else if (eq(c, "0")) begin
                            r.st.mode = M_ZERO;
                            r.st.flt = 1'b0;
                        end else if (eq(c, " ") || (c >= 9'h009 && c <= 9'h00d)) begin
                            r.st.mode = M_IDLE;
                        end else if (is_digit(c)) begin
                            r.st.mode = M_DECN;
                            r.st.flt = 1'b0;
                        end else if (is_alpha(c)) begin
                            r.st.mode = M_IDENT;
                            r.st.hits = '1;
                            r.st.len = 4'd0;
                            r.st = kw_step(r.st, c);
                        end else begin
                            r.n = 2'd1;
                            r.tk0 = TK_BAD;
                            r.st.halt = 1'b1;
                        end
                    end
                end
            end
            M_LINE: begin
                if (eq(c, "\n") || fl) r.st.mode = M_IDLE;
            end
            M_BLK, M_BLKSTAR, M_STR, M_STRESC: begin
                if (fl) begin
                    r.n = 2'd1;
                    r.tk0 = TK_ERR;
                    r.st.mode = M_IDLE;
                end else if (s.mode == M_BLK) begin
                    if (eq(c, "*")) r.st.mode = M_BLKSTAR;
                end else if (s.mode == M_BLKSTAR) begin
                    r.st.mode = eq(c, "/") ? M_IDLE : eq(c, "*") ? M_BLKSTAR : M_BLK;
                end else if (s.mode == M_STR) begin
                    if (eq(c, "\"")) begin
                        r.n = 2'd1;
                        r.tk0 = TK_STR;
                        r.st.mode = M_IDLE;
                    end else if (eq(c, "\\")) begin
                        r.st.mode = M_STRESC;
                    end
                end else begin
                    if (!(eq(c, "'") || eq(c, "\"") || eq(c, "?") || eq(c, "\\")
                          || eq(c, "a") || eq(c, "b") || eq(c, "f") || eq(c, "n")
                          || eq(c, "r") || eq(c, "t") || eq(c, "v") || eq(c, "x")
                          || (c >= 9'h030 && c <= 9'h037))) begin
                        r.n = 2'd1;
                        r.tk0 = TK_ERR;
                    end
                    r.st.mode = M_STR;
                end
            end
            M_IDENT: begin
                if (is_alpha(c) || is_digit(c)) begin
                    r.st = kw_step(s, c);
                end else begin
                    r.n = 2'd1;
                    r.tk0 = ident_kind(s);
                    r.st.mode = M_IDLE;
                    r.used = 1'b0;
                end
            end
            M_DOT1: begin
                if (eq(c, ".")) begin
                    r.st.mode = M_DOT2;
                end else begin
                    r.n = 2'd1;
                    r.tk0 = TK_DOT;
                    r.st.mode = M_IDLE;
                    r.used = 1'b0;
                end
            end
            M_DOT2: begin
                r.st.mode = M_IDLE;
                if (eq(c, ".")) begin
                    r.n = 2'd1;
                    r.tk0 = TK_DOTS3;
                end else begin
                    r.n = 2'd2;
                    r.tk0 = TK_DOT;
                    r.tk1 = TK_DOT;
                    r.used = 1'b0;
                end
            end
            M_SLASH, M_LT, M_GT: begin
                if (s.mode == M_SLASH && eq(c, "/")) r.st.mode = M_LINE;
                else if (s.mode == M_SLASH && eq(c, "*")) r.st.mode = M_BLK;
                else if (s.mode == M_LT && eq(c, "<")) r.st.mode = M_LT2;
                else if (s.mode == M_GT && eq(c, ">")) r.st.mode = M_GT2;
                else begin
                    r.st.mode = M_IDLE;
                    r.n = 2'd1;
                    if (eq(c, "=")) begin
                        r.tk0 = (s.mode == M_SLASH) ? TK_DIVEQ
                              : (s.mode == M_LT) ? TK_LE : TK_GE;
                    end else begin
                        r.tk0 = (s.mode == M_SLASH) ? TK_SL
                              : (s.mode == M_LT) ? TK_LESS : TK_MORE;
                        r.used = 1'b0;
                    end
                end
            end
            M_MINUS, M_PLUS, M_AMP, M_STAR, M_BANG, M_PERC, M_LT2, M_GT2, M_EQ,
            M_CARET, M_BAR, M_HASH: begin
                r.st.mode = M_IDLE;
                r.n = 2'd1;
                r.used = 1'b0;
                unique case (s.mode)
                    M_MINUS: r.tk0 = TK_SUB;
                    M_PLUS:  r.tk0 = TK_ADD;
                    M_AMP:   r.tk0 = TK_AMP;
                    M_STAR:  r.tk0 = TK_MUL;
                    M_BANG:  r.tk0 = TK_BANG;
                    M_PERC:  r.tk0 = TK_PC;
                    M_LT2:   r.tk0 = TK_SHL;
                    M_GT2:   r.tk0 = TK_SHR;
                    M_EQ:    r.tk0 = TK_ASSIGN;
                    M_CARET: r.tk0 = TK_CARET;
                    M_BAR:   r.tk0 = TK_BAR;
                    default: r.tk0 = TK_H;
                endcase
                if (s.mode == M_MINUS && eq(c, ">")) begin
                    r.tk0 = TK_ARROW; r.used = 1'b1;
                end else if (s.mode == M_MINUS && eq(c, "-")) begin
                    r.tk0 = TK_MM; r.used = 1'b1;
                end else if (s.mode == M_PLUS && eq(c, "+")) begin
                    r.tk0 = TK_PP; r.used = 1'b1;
                end else if (s.mode == M_AMP && eq(c, "&")) begin
                    r.tk0 = TK_ANDAND; r.used = 1'b1;
                end else if (s.mode == M_BAR && eq(c, "|")) begin
                    r.tk0 = TK_OROR; r.used = 1'b1;
                end else if (s.mode == M_HASH && eq(c, "#")) begin
                    r.tk0 = TK_HH; r.used = 1'b1;
                end else if (s.mode != M_HASH && eq(c, "=")) begin
                    r.used = 1'b1;
                    unique case (s.mode)
                        M_MINUS: r.tk0 = TK_SUBEQ;
                        M_PLUS:  r.tk0 = TK_ADDEQ;
                        M_AMP:   r.tk0 = TK_ANDEQ;
                        M_STAR:  r.tk0 = TK_MULEQ;
                        M_BANG:  r.tk0 = TK_NE;
                        M_PERC:  r.tk0 = TK_PCEQ;
                        M_LT2:   r.tk0 = TK_SHLEQ;
                        M_GT2:   r.tk0 = TK_SHREQ;
                        M_EQ:    r.tk0 = TK_EQEQ;
                        M_CARET: r.tk0 = TK_XOREQ;
                        default: r.tk0 = TK_OREQ;
                    endcase
                end
            end
            M_ZERO, M_OCT: begin
                if (s.mode == M_ZERO && (eq(c, "x") || eq(c, "X"))) begin
                    r.st.mode = M_HEX;
                    r.st.flt = 1'b0;
                end else if (is_digit(c)) begin
                    r.st.mode = M_OCT;
                end else if (eq(c, ".")) begin
                    r.st.mode = M_DECN;
                    r.st.flt = 1'b1;
                end else if (eq(c, "e") || eq(c, "E")) begin
                    r.st.mode = M_EXPS;
                    r.st.flt = 1'b1;
                end else begin
                    r.n = 2'd1; r.tk0 = TK_OCT; r.st.mode = M_IDLE; r.used = 1'b0;
                end
            end
            M_DECN: begin
                if (is_digit(c)) begin
                    r.st.mode = M_DECN;
                end else if (eq(c, ".") && !s.flt) begin
                    r.st.flt = 1'b1;
                end else if (eq(c, "e") || eq(c, "E")) begin
                    r.st.mode = M_EXPS;
                    r.st.flt = 1'b1;
                end else begin
                    r.n = 2'd1; r.tk0 = s.flt ? TK_FLT : TK_DEC;
                    r.st.mode = M_IDLE; r.used = 1'b0;
                end
            end
            M_EXPS, M_HEXEXPS: begin
                if (isexp) begin
                    r.st.mode = (s.mode == M_EXPS) ? M_EXP : M_HEXEXP;
                end else begin
                    r.n = 2'd1; r.tk0 = (s.mode == M_EXPS) ? TK_FLT : TK_HEXF;
                    r.st.mode = M_IDLE; r.used = 1'b0;
                end
            end
            M_EXP, M_HEXEXP: begin
                if (!is_digit(c)) begin
                    r.n = 2'd1; r.tk0 = (s.mode == M_EXP) ? TK_FLT : TK_HEXF;
                    r.st.mode = M_IDLE; r.used = 1'b0;
                end
            end
            default: begin
                if (is_hex(c)) begin
                    r.st.mode = M_HEX;
                end else if (eq(c, ".") && !s.flt) begin
                    r.st.flt = 1'b1;
                end else if (eq(c, "p") || eq(c, "P")) begin
                    r.st.mode = M_HEXEXPS;
                    r.st.flt = 1'b1;
                end else begin
                    r.n = 2'd1; r.tk0 = s.flt ? TK_HEXF : TK_HEXI;
                    r.st.mode = M_IDLE; r.used = 1'b0;
                end
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ctc_if.sv =====
// ----------------------------------------------------------------------------
// ctc channel interfaces
// Byte input channel and token output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctc_byte_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_req;
    logic        end_of_input;

    modport source (output valid, output byte_req, output end_of_input, input ready);
    modport sink (input valid, input byte_req, input end_of_input, output ready);
endinterface

interface ctc_tok_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic        last_of_run;

    modport source (output valid, output token_kind, output last_of_run, input ready);
    modport sink (input valid, input token_kind, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== hdl/c_token_classifier.sv =====
// ----------------------------------------------------------------------------
// c_token_classifier
// C lexer: source bytes in, token kind codes out.
// ----------------------------------------------------------------------------
// One byte is taken per clock. A byte completes zero to three tokens; the
// lexer state machine forms all of them in the cycle the byte is taken and
// parks them as one bundle in a two-entry queue. The output register sends
// one token per clock while the receiver is ready, so a byte with several
// tokens holds the output until all are sent; input stalls only when the
// queue fills. Tokens pass through the queue and then the output register.
`default_nettype none

module c_token_classifier (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ctc_byte_if.sink   i_in,
    ctc_tok_if.source  o_out
);
    import ctc_pkg::*;

    logic     space;
    logic     avail;
    logic     push;
    logic     pop;
    t_bundle  bundle;
    t_bundle  head;

    ctc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .i_byte   (i_in.byte_req),
        .i_eof    (i_in.end_of_input),
        .i_space  (space),
        .o_ready  (i_in.ready),
        .o_push   (push),
        .o_bundle (bundle)
    );

    ctc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (bundle),
        .i_pop    (pop),
        .o_space  (space),
        .o_avail  (avail),
        .o_head   (head)
    );

    ctc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_avail  (avail),
        .i_head   (head),
        .o_pop    (pop),
        .o_valid  (o_out.valid),
        .o_kind   (o_out.token_kind),
        .o_last   (o_out.last_of_run),
        .i_ready  (o_out.ready)
    );

endmodule

`default_nettype wire

// ===== hdl/ctc_front.sv =====
// ----------------------------------------------------------------------------
// ctc_front
// Lexer state machine: takes one byte per transfer and forms its token bundle.
// ----------------------------------------------------------------------------
`default_nettype none

module ctc_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_eof,
    input  wire logic             i_space,
    output logic                  o_ready,
    output logic                  o_push,
    output ctc_pkg::t_bundle      o_bundle
);
    import ctc_pkg::*;

    t_lex_st   r_st;
    t_lex_st   n_st;
    t_lex_st   s_rst;
    t_lex_res  a;
    t_lex_res  b;
    t_lex_res  f;
    logic      acc;
    logic [8:0] c;
    logic [5:0] cand [6];
    logic       cv [6];
    logic [2:0] cnt;

    assign o_ready = i_space;
    assign acc = i_valid & i_space;
    assign c = {1'b0, i_byte};

    always_comb begin
        s_rst = '{mode: M_IDLE, flt: 1'b0, hits: '0, len: 4'd0, halt: 1'b0};
        a = lex_step(r_st, c);
        if (!a.used) begin
            b = lex_step(a.st, c);
        end else begin
            b = a;
            b.n = 2'd0;
        end
        if (i_eof && !b.st.halt) begin
            f = lex_step(b.st, FLUSH_CH);
        end else begin
            f = b;
            f.n = 2'd0;
        end
        cand[0] = a.tk0; cv[0] = a.n != 2'd0;
        cand[1] = a.tk1; cv[1] = a.n == 2'd2;
        cand[2] = b.tk0; cv[2] = b.n != 2'd0;
        cand[3] = b.tk1; cv[3] = b.n == 2'd2;
        cand[4] = f.tk0; cv[4] = f.n != 2'd0;
        cand[5] = f.tk1; cv[5] = f.n == 2'd2;
        cnt = 3'd0;
        o_bundle.kinds = '0;
        for (int i = 0; i < 6; i++) begin
            if (cv[i] && cnt < 3'(MAX_TOK)) begin
                o_bundle.kinds[cnt[1:0]] = cand[i];
                cnt = cnt + 3'd1;
            end
        end
        if (r_st.halt) cnt = 3'd0;
        o_bundle.cnt = cnt[1:0];
        o_push = acc && cnt != 3'd0;
        n_st = r_st;
        if (acc) begin
            if (i_eof) n_st = s_rst;
            else if (!r_st.halt) n_st = f.st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '{mode: M_IDLE, flt: 1'b0, hits: '0, len: 4'd0, halt: 1'b0};
        end else begin
            r_st <= n_st;
        end
    end

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.halt |-> !o_push)
        else $error("halted lexer produced tokens");
    a_eof_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_eof |=> r_st.mode == M_IDLE && !r_st.halt)
        else $error("lexer state not cleared after end of file");

endmodule

`default_nettype wire

// ===== hdl/ctc_queue.sv =====
// ----------------------------------------------------------------------------
// ctc_queue
// Two-entry queue of token bundles between the lexer and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ctc_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire ctc_pkg::t_bundle i_bundle,
    input  wire logic             i_pop,
    output logic                  o_space,
    output logic                  o_avail,
    output ctc_pkg::t_bundle      o_head
);
    import ctc_pkg::*;

    t_bundle     r_mem [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;

    assign o_space = r_cnt != 2'd2;
    assign o_avail = r_cnt != 2'd0;
    assign o_head = r_mem[r_rptr];

    always_comb begin
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (i_pop) r_rptr <= ~r_rptr;
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_space)
        else $error("bundle queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_avail)
        else $error("bundle queue underflow");

endmodule

`default_nettype wire

// ===== hdl/ctc_back.sv =====
// ----------------------------------------------------------------------------
// ctc_back
// Output stage: sends the tokens of each bundle one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module ctc_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_avail,
    input  wire ctc_pkg::t_bundle i_head,
    output logic                  o_pop,
    output logic                  o_valid,
    output logic [5:0]            o_kind,
    output logic                  o_last,
    input  wire logic             i_ready
);
    import ctc_pkg::*;

    logic        r_valid;
    logic [5:0]  r_kind;
    logic        r_last;
    logic [1:0]  r_idx;
    logic        load;
    logic        at_end;

    assign load = (!r_valid || i_ready) && i_avail;
    assign at_end = r_idx == i_head.cnt - 2'd1;
    assign o_pop = load && at_end;
    assign o_valid = r_valid;
    assign o_kind = r_kind;
    assign o_last = r_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= i_head.kinds[r_idx];
            r_last <= at_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx <= at_end ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
